// ===== hw/rtl/cle_pkg.sv =====
// ----------------------------------------------------------------------------
// cle_pkg
// Shared constants and types of the console line editor.
// ----------------------------------------------------------------------------
`default_nettype none

package cle_pkg;

  localparam int LINE_CAPACITY = 32;
  localparam int CNT_W  = $clog2(LINE_CAPACITY + 1);
  localparam int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_DELETE    = 8'h7F;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;

  localparam logic CHAN_ECHO = 1'b0;
  localparam logic CHAN_LINE = 1'b1;

  // source of the next output word
  typedef enum logic [2:0] {
    SEL_RX,
    SEL_BS,
    SEL_SP,
    SEL_NL,
    SEL_CR,
    SEL_LINE
  } out_sel_t;

  typedef struct packed {
    logic     accept;    // latch received byte
    logic     fc_inc;    // store byte, bump fill count
    logic     fc_dec;
    logic     fc_clr;
    logic     ptr_clr;
    logic     rd_en;     // read store at pointer, advance pointer
    logic     out_load;
    out_sel_t out_sel;
    logic     out_last;
  } cle_cmd_t;

  typedef struct packed {
    logic is_erase;
    logic is_return;
    logic fc_zero;
    logic fc_full;
    logic out_free;
    logic ptr_end;
  } cle_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cle_ram.sv =====
// ----------------------------------------------------------------------------
// cle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cle_dp.sv =====
// ----------------------------------------------------------------------------
// cle_dp
// Datapath: byte latch, fill count, line store, read pointer, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        in_rx_byte,
  input  wire cle_pkg::cle_cmd_t cmd,
  output cle_pkg::cle_sts_t      sts,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_channel,
  output logic [7:0]             out_byte,
  output logic                   out_last
);

  logic [7:0]                  rx_r;
  logic [cle_pkg::CNT_W-1:0]   fc_r, fc_nxt;
  logic [cle_pkg::CNT_W-1:0]   ptr_r, ptr_nxt;
  logic                        ov_r, ov_nxt;
  logic                        och_r;
  logic [7:0]                  obyte_r;
  logic                        olast_r;
  logic [7:0]                  rd_data;
  logic [7:0]                  sel_byte;
  logic                        sel_chan;

  cle_ram #(
    .WIDTH(8),
    .DEPTH(cle_pkg::LINE_CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (cmd.fc_inc),
    .waddr(fc_r[cle_pkg::ADDR_W-1:0]),
    .wdata(rx_r),
    .re   (cmd.rd_en),
    .raddr(ptr_r[cle_pkg::ADDR_W-1:0]),
    .rdata(rd_data)
  );

  always_comb begin
    fc_nxt = fc_r;
    if (cmd.fc_clr) begin
      fc_nxt = '0;
    end else if (cmd.fc_dec) begin
      fc_nxt = fc_r - cle_pkg::CNT_W'(1);
    end else if (cmd.fc_inc) begin
      fc_nxt = fc_r + cle_pkg::CNT_W'(1);
    end

    ptr_nxt = ptr_r;
    if (cmd.ptr_clr) begin
      ptr_nxt = '0;
    end else if (cmd.rd_en) begin
      ptr_nxt = ptr_r + cle_pkg::CNT_W'(1);
    end

    sel_chan = cle_pkg::CHAN_ECHO;
    case (cmd.out_sel)
      cle_pkg::SEL_RX:   sel_byte = rx_r;
      cle_pkg::SEL_BS:   sel_byte = cle_pkg::CH_BACKSPACE;
      cle_pkg::SEL_SP:   sel_byte = cle_pkg::CH_SPACE;
      cle_pkg::SEL_NL:   sel_byte = cle_pkg::CH_NEWLINE;
      cle_pkg::SEL_CR:   sel_byte = cle_pkg::CH_RETURN;
      cle_pkg::SEL_LINE: begin
        sel_byte = rd_data;
        sel_chan = cle_pkg::CHAN_LINE;
      end
      default:           sel_byte = rx_r;
    endcase

    ov_nxt = ov_r;
    if (cmd.out_load) begin
      ov_nxt = 1'b1;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r <= '0;
      ov_r <= 1'b0;
    end else begin
      fc_r <= fc_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.accept) begin
      rx_r <= in_rx_byte;
    end
    if (cmd.out_load) begin
      och_r   <= sel_chan;
      obyte_r <= sel_byte;
      olast_r <= cmd.out_last;
    end
  end

  assign sts.is_erase  = (rx_r == cle_pkg::CH_BACKSPACE) || (rx_r == cle_pkg::CH_DELETE);
  assign sts.is_return = (rx_r == cle_pkg::CH_RETURN);
  assign sts.fc_zero   = (fc_r == '0);
  assign sts.fc_full   = (fc_r == cle_pkg::CNT_W'(cle_pkg::LINE_CAPACITY));
  assign sts.out_free  = !ov_r || !out_stall;
  assign sts.ptr_end   = (ptr_r == fc_r);

  assign out_valid   = ov_r;
  assign out_channel = och_r;
  assign out_byte    = obyte_r;
  assign out_last    = olast_r;

endmodule

`default_nettype wire

// ===== hw/rtl/cle_ctrl.sv =====
// ----------------------------------------------------------------------------
// cle_ctrl
// Controller: decodes each received byte and sequences echo and line dump.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   busy,
  input  wire cle_pkg::cle_sts_t sts,
  output cle_pkg::cle_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_ECHO,
    S_BS1,
    S_BS2,
    S_BS3,
    S_NL,
    S_CR,
    S_RD,
    S_WR
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    cmd.out_sel = cle_pkg::SEL_RX;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.is_erase) begin
          if (sts.fc_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.fc_dec = 1'b1;
            state_nxt  = S_BS1;
          end
        end else if (sts.is_return) begin
          state_nxt = S_NL;
        end else if (sts.fc_full) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.fc_inc = 1'b1;
          state_nxt  = S_ECHO;
        end
      end
      S_ECHO: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = cle_pkg::SEL_RX;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_BS1: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = cle_pkg::SEL_BS;
          state_nxt    = S_BS2;
        end
      end
      S_BS2: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = cle_pkg::SEL_SP;
          state_nxt    = S_BS3;
        end
      end
      S_BS3: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = cle_pkg::SEL_BS;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_NL: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = cle_pkg::SEL_NL;
          state_nxt    = S_CR;
        end
      end
      S_CR: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = cle_pkg::SEL_CR;
          cmd.out_last = sts.fc_zero;
          cmd.ptr_clr  = 1'b1;
          state_nxt    = sts.fc_zero ? S_IDLE : S_RD;
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        // pointer already past the byte now held in read data
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = cle_pkg::SEL_LINE;
          cmd.out_last = sts.ptr_end;
          if (sts.ptr_end) begin
            cmd.fc_clr = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/console_line_editor.sv =====
// ----------------------------------------------------------------------------
// console_line_editor
// Line editor for a serial console: echo, erase and line hand-off.
// ----------------------------------------------------------------------------
// Use: in_rx_byte carries one received character per word on a valid/stall
// channel. Each word produces a short run of result words on the out_
// channel: out_channel 0 is an echo for the transmitter, 1 a byte of the
// finished line; out_last marks the final word caused by that character.
// Erase (backspace or delete) on an empty line and ordinary characters on
// a full line produce nothing.
// Timing: one character at a time. in_stall is high from the accept edge
// until the character's last result word is loaded into the output
// register, or until it is decided if it produces nothing. After the
// accept edge the controller decides in S_DECIDE, then loads the first
// result word once the output register is free. The line store has a
// registered read port, so each dumped byte passes a read state (S_RD)
// and then a load state (S_WR).
// Reset clears the fill count, the controller and the output valid; the
// line store itself is not cleared, nothing unwritten is ever read.
// Receiver stall holds the output word; the controller waits with it.
// ----------------------------------------------------------------------------
`default_nettype none

module console_line_editor (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // received characters
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  // echo and line words
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_channel,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  cle_pkg::cle_cmd_t cmd;
  cle_pkg::cle_sts_t sts;
  logic              busy;

  // sequencer: decode, echo patterns, dump loop
  cle_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .busy    (busy),
    .sts     (sts),
    .cmd     (cmd)
  );

  // storage, counters and output register
  cle_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_rx_byte (in_rx_byte),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_channel(out_channel),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

  // one character in flight at a time
  assign in_stall = busy;

`ifndef SYNTH
  // never overwrite a word the receiver has not taken
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("output word overwritten while stalled");

  // store never written past capacity
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fc_inc |-> !sts.fc_full)
    else $error("write into full line store");

  // erase never underflows the fill count
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fc_dec |-> !sts.fc_zero)
    else $error("erase on empty line");

  // dump never reads beyond the stored bytes
  a_dump_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> !sts.ptr_end)
    else $error("line dump read past fill count");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/console_line_editor_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// console_line_editor_test
// Self-checking bench for the console line editor: typed lines, erase, return
// and full-line drops, checked word by word against an in-bench line model.
// ----------------------------------------------------------------------------

module console_line_editor_test;

  // Cycles with no word moving on either channel before the run is given up.
  // Worst legal gap is the long receiver hold-off below plus a few bursts.
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  // One expected result word.
  typedef struct packed {
    logic       chan;
    logic [7:0] data;
    logic       last;
  } word_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic       out_channel;
  logic [7:0] out_byte;
  logic       out_last;

  // Line model: what the editor should hold right now.
  logic [7:0]  line_buf [cle_pkg::LINE_CAPACITY];
  int unsigned line_len;

  // Words the editor still owes us, oldest first.
  word_t due_words[$];

  int  fail_count;
  int  active_items;   // characters that produced at least one word
  bit  idle_on;        // random bursts on both sides
  int  hold_req;       // long receiver hold-off, counted down by the receiver

  console_line_editor u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_rx_byte  (in_rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_channel (out_channel),
    .out_byte    (out_byte),
    .out_last    (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Line model
  // --------------------------------------------------------------------------
  function automatic void owe_word(input logic chan, input logic [7:0] data,
                                   input logic last);
    word_t w;
    w.chan = chan;
    w.data = data;
    w.last = last;
    due_words.push_back(w);
  endfunction

  // Applies one received character to the line model and queues the words
  // it must cause. Returns how many were queued.
  function automatic int apply_keystroke(input logic [7:0] ch);
    int start_size;
    int i;
    start_size = due_words.size();
    if (ch == cle_pkg::CH_BACKSPACE || ch == cle_pkg::CH_DELETE) begin
      // erase on an empty line is swallowed
      if (line_len != 0) begin
        line_len--;
        owe_word(cle_pkg::CHAN_ECHO, cle_pkg::CH_BACKSPACE, 1'b0);
        owe_word(cle_pkg::CHAN_ECHO, cle_pkg::CH_SPACE, 1'b0);
        owe_word(cle_pkg::CHAN_ECHO, cle_pkg::CH_BACKSPACE, 1'b1);
      end
    end else if (ch == cle_pkg::CH_RETURN) begin
      // newline, return, then the line itself; last goes on the final word
      owe_word(cle_pkg::CHAN_ECHO, cle_pkg::CH_NEWLINE, 1'b0);
      owe_word(cle_pkg::CHAN_ECHO, cle_pkg::CH_RETURN, line_len == 0);
      for (i = 0; i < int'(line_len); i++)
        owe_word(cle_pkg::CHAN_LINE, line_buf[i], i + 1 == int'(line_len));
      line_len = 0;
    end else if (line_len < cle_pkg::LINE_CAPACITY) begin
      // everything else, control bytes included, is stored and echoed;
      // on a full line it is dropped silently
      line_buf[line_len] = ch;
      line_len++;
      owe_word(cle_pkg::CHAN_ECHO, ch, 1'b1);
    end
    return due_words.size() - start_size;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: called at a falling edge, returns at a falling edge. Valid stays
  // high straight into the next character unless a gap is drawn.
  // --------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] ch);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= ch;
    do @(posedge clk); while (in_stall);
    if (apply_keystroke(ch) > 0)
      active_items++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] any_plain();
    logic [7:0] ch;
    do ch = 8'($urandom_range(0, 255));
    while (ch == cle_pkg::CH_BACKSPACE || ch == cle_pkg::CH_DELETE ||
           ch == cle_pkg::CH_RETURN);
    return ch;
  endfunction

  function automatic logic [7:0] any_erase();
    return $urandom_range(0, 1) ? cle_pkg::CH_BACKSPACE : cle_pkg::CH_DELETE;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, plus the long hold-off when requested.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int burst_left;
    burst_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        out_stall <= 1'b1;
        hold_req--;
      end else if (burst_left > 0) begin
        out_stall <= 1'b1;
        burst_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall  <= 1'b1;
        burst_left = $urandom_range(1, 12) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result check: every accepted word against the oldest one owed.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (due_words.size() == 0) begin
        $error("unexpected word: channel %0d byte %02h last %0d",
               out_channel, out_byte, out_last);
        fail_count++;
      end else begin
        w = due_words.pop_front();
        if (out_channel !== w.chan) begin
          $error("out_channel: expected %0d, got %0d", w.chan, out_channel);
          fail_count++;
        end
        if (out_byte !== w.data) begin
          $error("out_byte: expected %02h, got %02h", w.data, out_byte);
          fail_count++;
        end
        if (out_last !== w.last) begin
          $error("out_last: expected %0d, got %0d", w.last, out_last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: nothing moving on either channel for too long.
  always @(posedge clk) begin
    int quiet;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes and each corner: erase and return on an empty line,
  // control bytes stored as text, erase with both codes, return with text.
  task automatic test_directed();
    logic [7:0] seq [] = '{cle_pkg::CH_BACKSPACE, cle_pkg::CH_DELETE,
                           cle_pkg::CH_RETURN, 8'h00, 8'hFF,
                           cle_pkg::CH_NEWLINE, 8'h80, 8'h55, 8'hAA,
                           cle_pkg::CH_BACKSPACE, 8'h7E, cle_pkg::CH_DELETE,
                           8'h01, cle_pkg::CH_RETURN, cle_pkg::CH_SPACE,
                           cle_pkg::CH_RETURN, cle_pkg::CH_DELETE,
                           cle_pkg::CH_RETURN};
    foreach (seq[i]) send_char(seq[i]);
  endtask

  // Fill the line, overflow it, edit at the top, then dump a full line.
  task automatic test_full_line();
    int i;
    for (i = 0; i < cle_pkg::LINE_CAPACITY + 2; i++) send_char(any_plain());
    send_char(any_erase());
    send_char(any_plain());
    send_char(any_plain());   // dropped again
    send_char(cle_pkg::CH_RETURN);
    for (i = 0; i < cle_pkg::LINE_CAPACITY; i++) send_char(any_plain());
    send_char(cle_pkg::CH_RETURN);     // most words one character can cause
  endtask

  // Mostly well-formed lines with random text and edits; some noise and
  // lines that are erased away without a return.
  task automatic test_random_lines(input int n_active);
    int start;
    int len;
    int i;
    start = active_items;
    while (active_items - start < n_active) begin
      case ($urandom_range(0, 9))
        0: begin
          send_char(8'($urandom_range(0, 255)));
        end
        1: begin
          len = $urandom_range(0, 4);
          for (i = 0; i < len; i++) send_char(any_plain());
          for (i = 0; i < len + 2; i++) send_char(any_erase());
        end
        default: begin
          len = ($urandom_range(0, 7) == 0)
                  ? $urandom_range(0, cle_pkg::LINE_CAPACITY + 8)
                  : $urandom_range(0, 8);
          for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 5) == 0) send_char(any_erase());
            else                           send_char(any_plain());
          end
          send_char(cle_pkg::CH_RETURN);
        end
      endcase
    end
  endtask

  // Receiver holds off for a long stretch while characters keep coming, so
  // the output register fills and the editor stalls its input.
  task automatic test_backpressure();
    int i;
    hold_req = HOLD_CYCLES;
    for (i = 0; i < 20; i++) send_char(any_plain());
    send_char(cle_pkg::CH_RETURN);
  endtask

  // Last stretch at full rate on both sides.
  task automatic test_full_rate();
    idle_on = 1'b0;
    test_random_lines(40);
  endtask

  initial begin : main
    fail_count   = 0;
    active_items = 0;
    line_len     = 0;
    hold_req     = 0;
    idle_on      = 1'b1;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_rx_byte   = 8'h00;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_full_line();
    test_random_lines(120);
    test_backpressure();
    test_random_lines(110);
    test_full_rate();

    in_valid <= 1'b0;
    // watchdog covers a word that never comes
    while (due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("tb: success");
    else                 $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/cle_pkg.sv
hw/rtl/cle_ram.sv
hw/rtl/cle_dp.sv
hw/rtl/cle_ctrl.sv
hw/rtl/console_line_editor.sv
tb/sv/console_line_editor_test.sv
